[rtl/core/udp_ipv4_header_checksum_macros.svh]
// Assertion helpers for the checksum offload block.
`ifndef UDP_IPV4_HEADER_CHECKSUM_MACROS_SVH
`define UDP_IPV4_HEADER_CHECKSUM_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define UCK_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define UCK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define UCK_ASSERT_IMPL(label, clk, rst, ante, cons)
`define UCK_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/core/udp_ck_pkg.sv]
package udp_ck_pkg;

  localparam int FRAME_BYTES_DEF = 4096;

  localparam int SUM_W   = 16;
  localparam int COUNT_W = 12;
  localparam int LEN_W   = 12;
  localparam int FRAME_W = 13;

  localparam int ETH_BYTES  = 14;
  localparam int IPH_BYTES  = 20;
  localparam int UDPH_BYTES = 8;
  localparam int HDR_BYTES  = ETH_BYTES + IPH_BYTES + UDPH_BYTES;

  localparam logic [COUNT_W-1:0] COUNT_CAP = '1;

  localparam logic [SUM_W-1:0] ONES        = 16'hFFFF;
  localparam logic [SUM_W-1:0] IP_VER_IHL  = 16'h4500;
  localparam logic [7:0]       IP_TTL      = 8'd64;
  localparam logic [7:0]       IP_PROTO    = 8'd17;

  localparam logic [1:0] REG_SOURCE_IP   = 2'd0;
  localparam logic [1:0] REG_DEST_IP     = 2'd1;
  localparam logic [1:0] REG_SOURCE_PORT = 2'd2;
  localparam logic [1:0] REG_DEST_PORT   = 2'd3;

  // closed payload: final ones'-complement sum and byte count
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
  } s1_t;

  // lengths and partial sums ahead of the final folds
  typedef struct packed {
    logic               err;
    logic [LEN_W-1:0]   tlen;
    logic [LEN_W-1:0]   ulen;
    logic [FRAME_W-1:0] frame;
    logic [SUM_W-1:0]   ip_pre;
    logic [SUM_W-1:0]   udp_pre;
    logic [SUM_W-1:0]   addr_sum;
    logic [SUM_W-1:0]   port_sum;
  } s2_t;

  // 16-bit ones'-complement add, end-around carry
  function automatic logic [SUM_W-1:0] oc_add(input logic [SUM_W-1:0] a,
                                              input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W-1:0] + SUM_W'(s[SUM_W]);
  endfunction

endpackage

[rtl/core/udp_ck_in_if.sv]
interface udp_ck_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;

  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

[rtl/core/udp_ck_out_if.sv]
interface udp_ck_out_if;
  logic                             valid;
  logic                             ready;
  logic                             status;
  logic [udp_ck_pkg::LEN_W-1:0]     ip_total_length;
  logic [udp_ck_pkg::SUM_W-1:0]     ip_header_checksum;
  logic [udp_ck_pkg::LEN_W-1:0]     udp_length;
  logic [udp_ck_pkg::SUM_W-1:0]     udp_checksum;
  logic [udp_ck_pkg::FRAME_W-1:0]   frame_length;

  modport source (output valid, output status, output ip_total_length,
                  output ip_header_checksum, output udp_length,
                  output udp_checksum, output frame_length, input ready);
  modport sink   (input valid, input status, input ip_total_length,
                  input ip_header_checksum, input udp_length,
                  input udp_checksum, input frame_length, output ready);
endinterface

[rtl/core/udp_ipv4_header_checksum.sv]
// UDP/IPv4 checksum offload: one payload byte accepted per cycle unless result.ready back-pressure stalls the pipeline.
// Pipeline: sum/count latched at the edge that accepts the last byte, then length
//   stage, then fold/output register; a low result.ready can stall each stage.
// Throughput: 1 item per cycle on the byte side unless stalled; one result per payload.
// Reset (rst, synchronous, active high) clears the running sum, byte count,
//   pipeline valids and the four address/port registers to zero.
module udp_ipv4_header_checksum #(
  parameter int FRAME_BYTES = udp_ck_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // byte stream in, header fields out
  udp_ck_in_if.sink    payload,
  udp_ck_out_if.source result
);

  // address and port registers; the user must write them only while the block is idle (not enforced by the block)
  logic [31:0]                  source_ip;
  logic [31:0]                  dest_ip;
  logic [udp_ck_pkg::SUM_W-1:0] source_port;
  logic [udp_ck_pkg::SUM_W-1:0] dest_port;

  // pipeline hand-offs
  logic            s1_valid, s1_ready;
  udp_ck_pkg::s1_t s1;
  logic            s2_valid, s2_ready;
  udp_ck_pkg::s2_t s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_ip   <= '0;
      dest_ip     <= '0;
      source_port <= '0;
      dest_port   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        udp_ck_pkg::REG_SOURCE_IP:   source_ip   <= cfg_data;
        udp_ck_pkg::REG_DEST_IP:     dest_ip     <= cfg_data;
        udp_ck_pkg::REG_SOURCE_PORT: source_port <= cfg_data[15:0];
        udp_ck_pkg::REG_DEST_PORT:   dest_port   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stage 1: end-around-carry add per byte pair, count saturating at 4095;
  // on the last byte the padded final sum and count are latched
  udp_ck_acc u_acc (
    .clk      (clk),
    .rst      (rst),
    .payload  (payload),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1)
  );

  // stage 2: length check, lengths, address/port/length partial sums
  udp_ck_hdr #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_hdr (
    .clk         (clk),
    .rst         (rst),
    .source_ip   (source_ip),
    .dest_ip     (dest_ip),
    .source_port (source_port),
    .dest_port   (dest_port),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1          (s1),
    .s2_valid    (s2_valid),
    .s2_ready    (s2_ready),
    .s2          (s2)
  );

  // stage 3: final folds, complement, zero substitution, output register
  udp_ck_out u_out (
    .clk      (clk),
    .rst      (rst),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2       (s2),
    .result   (result)
  );

endmodule

[rtl/core/udp_ck_acc.sv]
`include "udp_ipv4_header_checksum_macros.svh"

module udp_ck_acc (
  input  logic              clk,
  input  logic              rst,
  udp_ck_in_if.sink         payload,
  output logic              s1_valid,
  input  logic              s1_ready,
  output udp_ck_pkg::s1_t   s1
);

  logic [udp_ck_pkg::SUM_W-1:0]   running_sum, running_sum_next;
  logic [udp_ck_pkg::COUNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]                     held_high_byte, held_high_byte_next;
  logic                           odd_phase, odd_phase_next;

  logic                           fire;
  logic                           s1_free;
  logic [udp_ck_pkg::SUM_W-1:0]   word;
  logic [udp_ck_pkg::SUM_W-1:0]   sum_add;

  assign s1_free       = !s1_valid || s1_ready;
  assign payload.ready = s1_free;
  assign fire          = payload.valid && payload.ready;

  // a held high byte pairs with this one; a lone last byte is zero padded
  assign word    = odd_phase ? {held_high_byte, payload.payload_byte}
                             : {payload.payload_byte, 8'h00};
  assign sum_add = udp_ck_pkg::oc_add(running_sum, word);

  always_comb begin
    running_sum_next    = running_sum;
    byte_count_next     = byte_count;
    held_high_byte_next = held_high_byte;
    odd_phase_next      = odd_phase;
    if (fire) begin
      if (payload.last_byte) begin
        running_sum_next    = '0;
        byte_count_next     = '0;
        held_high_byte_next = '0;
        odd_phase_next      = 1'b0;
      end else if (odd_phase) begin
        running_sum_next    = sum_add;
        held_high_byte_next = '0;
        odd_phase_next      = 1'b0;
        byte_count_next     = (byte_count == udp_ck_pkg::COUNT_CAP) ? byte_count
                                                                    : byte_count + 1'b1;
      end else begin
        held_high_byte_next = payload.payload_byte;
        odd_phase_next      = 1'b1;
        byte_count_next     = (byte_count == udp_ck_pkg::COUNT_CAP) ? byte_count
                                                                    : byte_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      byte_count     <= '0;
      held_high_byte <= '0;
      odd_phase      <= 1'b0;
      s1_valid       <= 1'b0;
    end else begin
      running_sum    <= running_sum_next;
      byte_count     <= byte_count_next;
      held_high_byte <= held_high_byte_next;
      odd_phase      <= odd_phase_next;
      if (s1_free) begin
        s1_valid <= fire && payload.last_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && fire && payload.last_byte) begin
      s1.sum   <= sum_add;
      s1.count <= (byte_count == udp_ck_pkg::COUNT_CAP) ? byte_count
                                                        : byte_count + 1'b1;
    end
  end

  `UCK_ASSERT_NEXT(a_clear_after_last, clk, rst, fire && payload.last_byte, byte_count == '0 && !odd_phase && s1_valid)
  `UCK_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !s1_ready, s1_valid && $stable(s1))
  `UCK_ASSERT_IMPL(a_ready_when_empty, clk, rst, !s1_valid, payload.ready)

endmodule

[rtl/core/udp_ck_hdr.sv]
module udp_ck_hdr #(
  parameter int FRAME_BYTES = udp_ck_pkg::FRAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [31:0]                    source_ip,
  input  logic [31:0]                    dest_ip,
  input  logic [udp_ck_pkg::SUM_W-1:0]   source_port,
  input  logic [udp_ck_pkg::SUM_W-1:0]   dest_port,
  input  logic                           s1_valid,
  output logic                           s1_ready,
  input  udp_ck_pkg::s1_t                s1,
  output logic                           s2_valid,
  input  logic                           s2_ready,
  output udp_ck_pkg::s2_t                s2
);

  localparam int MAX_LOAD = FRAME_BYTES - udp_ck_pkg::HDR_BYTES;

  udp_ck_pkg::s2_t                s2_next;
  logic [udp_ck_pkg::LEN_W-1:0]   ulen;
  logic [udp_ck_pkg::SUM_W-1:0]   len_pair;

  assign s1_ready = !s2_valid || s2_ready;

  always_comb begin
    ulen     = s1.count + udp_ck_pkg::LEN_W'(udp_ck_pkg::UDPH_BYTES);
    // UDP length appears twice: pseudo-header and UDP header; protocol rides along
    len_pair = {3'b000, ulen, 1'b0} + udp_ck_pkg::SUM_W'(udp_ck_pkg::IP_PROTO);

    s2_next.err      = s1.count > udp_ck_pkg::COUNT_W'(MAX_LOAD);
    s2_next.ulen     = ulen;
    s2_next.tlen     = ulen + udp_ck_pkg::LEN_W'(udp_ck_pkg::IPH_BYTES);
    s2_next.frame    = {1'b0, s1.count} + udp_ck_pkg::FRAME_W'(udp_ck_pkg::HDR_BYTES);
    // no wrap: constant words plus a 12-bit length stay below 0xFFFF
    s2_next.ip_pre   = udp_ck_pkg::IP_VER_IHL + {udp_ck_pkg::IP_TTL, udp_ck_pkg::IP_PROTO}
                     + udp_ck_pkg::SUM_W'(s2_next.tlen);
    s2_next.udp_pre  = udp_ck_pkg::oc_add(len_pair, s1.sum);
    s2_next.addr_sum = udp_ck_pkg::oc_add(udp_ck_pkg::oc_add(source_ip[31:16], source_ip[15:0]),
                                          udp_ck_pkg::oc_add(dest_ip[31:16], dest_ip[15:0]));
    s2_next.port_sum = udp_ck_pkg::oc_add(source_port, dest_port);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      s2 <= s2_next;
    end
  end

endmodule

[rtl/core/udp_ck_out.sv]
`include "udp_ipv4_header_checksum_macros.svh"

module udp_ck_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              s2_valid,
  output logic              s2_ready,
  input  udp_ck_pkg::s2_t   s2,
  udp_ck_out_if.source      result
);

  logic [udp_ck_pkg::SUM_W-1:0] ip_ck;
  logic [udp_ck_pkg::SUM_W-1:0] udp_fold;
  logic [udp_ck_pkg::SUM_W-1:0] udp_ck;
  logic                         res_valid;

  assign s2_ready     = !res_valid || result.ready;
  assign result.valid = res_valid;

  always_comb begin
    ip_ck    = ~udp_ck_pkg::oc_add(s2.ip_pre, s2.addr_sum);
    udp_fold = ~udp_ck_pkg::oc_add(udp_ck_pkg::oc_add(s2.addr_sum, s2.port_sum), s2.udp_pre);
    // a computed zero goes out as all ones
    udp_ck   = (udp_fold == '0) ? udp_ck_pkg::ONES : udp_fold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s2_ready) begin
      res_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      result.status <= s2.err;
      if (s2.err) begin
        result.ip_total_length    <= '0;
        result.ip_header_checksum <= '0;
        result.udp_length         <= '0;
        result.udp_checksum       <= '0;
        result.frame_length       <= '0;
      end else begin
        result.ip_total_length    <= s2.tlen;
        result.ip_header_checksum <= ip_ck;
        result.udp_length         <= s2.ulen;
        result.udp_checksum       <= udp_ck;
        result.frame_length       <= s2.frame;
      end
    end
  end

  `UCK_ASSERT_IMPL(a_err_zero, clk, rst, res_valid && result.status, result.ip_total_length == '0 && result.udp_checksum == '0 && result.frame_length == '0)
  `UCK_ASSERT_IMPL(a_udp_nonzero, clk, rst, res_valid && !result.status, result.udp_checksum != '0)
  `UCK_ASSERT_IMPL(a_len_rel, clk, rst, res_valid && !result.status, result.ip_total_length == result.udp_length + 12'd20 && result.frame_length == {1'b0, result.ip_total_length} + 13'd14)

endmodule
